// ----- rtl/gpd_pkg.sv -----
// ----------------------------------------------------------------------------
// gpd_pkg
// shared widths, register indexes and command codes for the gap profile
// distance core
// ----------------------------------------------------------------------------
package gpd_pkg;

    localparam int GAP_W     = 16;
    localparam int FRAC_W    = 16;
    localparam int MASK_W    = 5;
    localparam int NUM_GAPS  = 5;
    localparam int Q_W       = GAP_W + FRAC_W;
    localparam int SQ_W      = 2 * Q_W;
    localparam int TERM_W    = SQ_W - FRAC_W;
    localparam int DIST_W    = 48;
    localparam int SUM_W     = TERM_W + 3;
    localparam int DIV_STEPS = 4;
    localparam int DIV_STAGES = Q_W / DIV_STEPS;
    localparam int LANE_LAT  = DIV_STAGES + 2;
    localparam int PIPE_LAT  = LANE_LAT + 3;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic [SUM_W-1:0]  SUM_LIM  = SUM_W'(64'(DIST_MAX) / 64'd100);

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_END_GAP_LEFT    = 3'd0,
        REG_BOGIE_GAP_LEFT  = 3'd1,
        REG_MIDDLE_GAP      = 3'd2,
        REG_BOGIE_GAP_RIGHT = 3'd3,
        REG_END_GAP_RIGHT   = 3'd4,
        REG_PRESENT_MASK    = 3'd5
    } t_cfg_reg;

    typedef enum logic [1:0] {
        CMD_MATCH       = 2'd0,
        CMD_INCLUSION   = 2'd1,
        CMD_REV_MATCH   = 2'd2,
        CMD_REV_INCL    = 2'd3
    } t_cmd;

    typedef logic [GAP_W-1:0] t_gap;

endpackage

// ----- rtl/gap_profile_distance_core.sv -----
// ----------------------------------------------------------------------------
// gap_profile_distance_core
// distance between a candidate five-gap profile and a configured reference
// ----------------------------------------------------------------------------
// pipeline: the divide and square lanes, then the partial-sum and sum registers,
// then the registered scaling and saturation of the output beat
// throughput: one beat per cycle; the whole pipeline holds while the output
// beat waits
// reset: synchronous active low, clears valid bits and reference registers
module gap_profile_distance_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cand_end_gap_left, cand_bogie_gap_left, cand_middle_gap,
    // cand_bogie_gap_right, cand_end_gap_right, cand_present_mask, 3 zero bits
    input  logic [87:0] s_axis_tdata,
    // command
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // distance_q16
    output logic [47:0] m_axis_tdata,
    // no_match
    output logic        m_axis_tuser
);

    localparam int GW = gpd_pkg::GAP_W;
    localparam int NG = gpd_pkg::NUM_GAPS;
    localparam int MW = gpd_pkg::MASK_W;
    localparam int LL = gpd_pkg::LANE_LAT;
    localparam int PL = gpd_pkg::PIPE_LAT;

    gpd_pkg::t_gap   r_ref_gap [NG];
    logic [MW-1:0]   r_ref_mask;

    logic            r_vld [PL];
    logic            r_nm  [PL];

    logic            w_en, w_acc, w_rev, w_ok;
    logic [MW-1:0]   w_cmask, w_cm;
    gpd_pkg::t_cmd   w_cmd;

    logic [gpd_pkg::TERM_W-1:0] w_term [NG];
    logic [gpd_pkg::SUM_W-1:0]  r_s01, r_s23, r_s4, r_sum;
    logic [gpd_pkg::SUM_W-1:0]  w_scaled;
    logic [gpd_pkg::DIST_W-1:0] r_dist;

    assign w_en          = !r_vld[PL-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign w_acc         = s_axis_tvalid && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NG; i++) r_ref_gap[i] <= '0;
            r_ref_mask <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                gpd_pkg::REG_END_GAP_LEFT:    r_ref_gap[0] <= i_cfg_wdata[GW-1:0];
                gpd_pkg::REG_BOGIE_GAP_LEFT:  r_ref_gap[1] <= i_cfg_wdata[GW-1:0];
                gpd_pkg::REG_MIDDLE_GAP:      r_ref_gap[2] <= i_cfg_wdata[GW-1:0];
                gpd_pkg::REG_BOGIE_GAP_RIGHT: r_ref_gap[3] <= i_cfg_wdata[GW-1:0];
                gpd_pkg::REG_END_GAP_RIGHT:   r_ref_gap[4] <= i_cfg_wdata[GW-1:0];
                gpd_pkg::REG_PRESENT_MASK:    r_ref_mask   <= i_cfg_wdata[MW-1:0];
                default: ;
            endcase
        end
    end

    // presence test
    assign w_cmd   = gpd_pkg::t_cmd'(s_axis_tuser);
    assign w_rev   = (w_cmd == gpd_pkg::CMD_REV_MATCH) || (w_cmd == gpd_pkg::CMD_REV_INCL);
    assign w_cmask = s_axis_tdata[NG*GW +: MW];

    always_comb begin
        for (int i = 0; i < MW; i++) w_cm[i] = w_rev ? w_cmask[MW-1-i] : w_cmask[i];
    end

    assign w_ok = ((w_cmd == gpd_pkg::CMD_INCLUSION) || (w_cmd == gpd_pkg::CMD_REV_INCL))
                ? ((r_ref_mask & ~w_cm) == '0) : (w_cm == r_ref_mask);

    for (genvar g = 0; g < NG; g++) begin : g_lane
        gpd_term u_term (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_a    (s_axis_tdata[g*GW +: GW]),
            .i_b    (w_rev ? r_ref_gap[NG-1-g] : r_ref_gap[g]),
            .o_term (w_term[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PL; i++) r_vld[i] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= w_acc;
            for (int i = 1; i < PL; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nm[0] <= !w_ok;
            for (int i = 1; i < PL; i++) r_nm[i] <= r_nm[i-1];
            r_s01 <= gpd_pkg::SUM_W'(w_term[0]) + gpd_pkg::SUM_W'(w_term[1]);
            r_s23 <= gpd_pkg::SUM_W'(w_term[2]) + gpd_pkg::SUM_W'(w_term[3]);
            r_s4  <= gpd_pkg::SUM_W'(w_term[4]);
            r_sum <= r_s01 + r_s23 + r_s4;
            if (r_nm[LL+1] || (r_sum > gpd_pkg::SUM_LIM)) begin
                r_dist <= gpd_pkg::DIST_MAX;
            end else begin
                r_dist <= w_scaled[gpd_pkg::DIST_W-1:0];
            end
        end
    end

    // times 100 as 64 + 32 + 4
    assign w_scaled = (r_sum << 6) + (r_sum << 5) + (r_sum << 2);

    assign m_axis_tvalid = r_vld[PL-1];
    assign m_axis_tdata  = r_dist;
    assign m_axis_tuser  = r_nm[PL-1];

endmodule

// ----- rtl/gpd_term.sv -----
// ----------------------------------------------------------------------------
// gpd_term
// one gap pair: pipelined restoring divide of max/min in Q16.16, then the
// scaled square of the ratio excess
// ----------------------------------------------------------------------------
module gpd_term (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  gpd_pkg::t_gap             i_a,
    input  gpd_pkg::t_gap             i_b,
    output logic [gpd_pkg::TERM_W-1:0] o_term
);

    localparam int GW = gpd_pkg::GAP_W;
    localparam int QW = gpd_pkg::Q_W;
    localparam int NS = gpd_pkg::DIV_STAGES;

    logic [GW-1:0] r_big, r_small;
    logic          r_zero;

    logic [GW-1:0] r_rem [NS];
    logic [QW-1:0] r_dvd [NS];
    logic [QW-1:0] r_quo [NS];
    logic [GW-1:0] r_dsr [NS];
    logic          r_zp  [NS];

    logic [GW-1:0] w_rem_in [NS];
    logic [QW-1:0] w_dvd_in [NS];
    logic [QW-1:0] w_quo_in [NS];
    logic [GW-1:0] w_dsr_in [NS];
    logic          w_zp_in  [NS];

    logic [gpd_pkg::SQ_W-1:0] r_sq;
    logic [QW-1:0]            w_e;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_big   <= (i_a > i_b) ? i_a : i_b;
            r_small <= (i_a > i_b) ? i_b : i_a;
            r_zero  <= (i_a == '0) || (i_b == '0);
        end
    end

    assign w_rem_in[0] = '0;
    assign w_dvd_in[0] = {r_big, {gpd_pkg::FRAC_W{1'b0}}};
    assign w_quo_in[0] = '0;
    assign w_dsr_in[0] = r_small;
    assign w_zp_in[0]  = r_zero;

    for (genvar k = 1; k < NS; k++) begin : g_link
        assign w_rem_in[k] = r_rem[k-1];
        assign w_dvd_in[k] = r_dvd[k-1];
        assign w_quo_in[k] = r_quo[k-1];
        assign w_dsr_in[k] = r_dsr[k-1];
        assign w_zp_in[k]  = r_zp[k-1];
    end

    for (genvar k = 0; k < NS; k++) begin : g_div
        logic [GW-1:0] n_rem;
        logic [QW-1:0] n_dvd, n_quo;

        always_comb begin
            logic [GW:0] rx;
            n_rem = w_rem_in[k];
            n_dvd = w_dvd_in[k];
            n_quo = w_quo_in[k];
            for (int j = 0; j < gpd_pkg::DIV_STEPS; j++) begin
                rx    = {n_rem, n_dvd[QW-1]};
                n_dvd = {n_dvd[QW-2:0], 1'b0};
                if (rx >= {1'b0, w_dsr_in[k]}) begin
                    rx    = rx - {1'b0, w_dsr_in[k]};
                    n_quo = {n_quo[QW-2:0], 1'b1};
                end else begin
                    n_quo = {n_quo[QW-2:0], 1'b0};
                end
                n_rem = rx[GW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_dvd[k] <= n_dvd;
                r_quo[k] <= n_quo;
                r_dsr[k] <= w_dsr_in[k];
                r_zp[k]  <= w_zp_in[k];
            end
        end
    end

    // quotient is at least one since max >= min
    assign w_e = r_zp[NS-1] ? '0 : r_quo[NS-1] - (QW'(1) << gpd_pkg::FRAC_W);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= w_e * w_e;
        end
    end

    assign o_term = r_sq[gpd_pkg::SQ_W-1:gpd_pkg::FRAC_W];

endmodule
